FILE: rtl/itpc_pkg.sv
// itpc_pkg: shared types, character codes and classifying functions
// for the infix to postfix converter; depends on nothing
package itpc_pkg;

   localparam int SymWidth = 8;

   localparam logic [SymWidth-1:0] CH_PLUS   = 8'h2B;
   localparam logic [SymWidth-1:0] CH_MINUS  = 8'h2D;
   localparam logic [SymWidth-1:0] CH_STAR   = 8'h2A;
   localparam logic [SymWidth-1:0] CH_SLASH  = 8'h2F;
   localparam logic [SymWidth-1:0] CH_CARET  = 8'h5E;
   localparam logic [SymWidth-1:0] CH_LPAREN = 8'h28;
   localparam logic [SymWidth-1:0] CH_RPAREN = 8'h29;
   localparam logic [SymWidth-1:0] CH_SPACE  = 8'h20;
   localparam logic [SymWidth-1:0] CH_TAB    = 8'h09;
   localparam logic [SymWidth-1:0] CH_CR     = 8'h0D;
   localparam logic [SymWidth-1:0] CH_ZERO   = 8'h30;
   localparam logic [SymWidth-1:0] CH_NINE   = 8'h39;
   localparam logic [SymWidth-1:0] CH_UP_A   = 8'h41;
   localparam logic [SymWidth-1:0] CH_UP_Z   = 8'h5A;
   localparam logic [SymWidth-1:0] CH_LO_A   = 8'h61;
   localparam logic [SymWidth-1:0] CH_LO_Z   = 8'h7A;
   localparam logic [SymWidth-1:0] CH_NUL    = 8'h00;

   localparam logic MODE_CHAR = 1'b0;
   localparam logic MODE_END  = 1'b1;

   typedef logic [SymWidth-1:0] sym_type;
   typedef logic [1:0]          prec_type;

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } state_type;

   // shift control handed to every stack cell
   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

   function automatic prec_type prec_of(input sym_type ch);
      prec_type p;
      p = 2'd0;
      case (ch)
         CH_PLUS, CH_MINUS: p = 2'd1;
         CH_STAR, CH_SLASH: p = 2'd2;
         CH_CARET:          p = 2'd3;
         default:           p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic logic is_blank(input sym_type ch);
      return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
   endfunction

   function automatic logic is_alnum(input sym_type ch);
      return ((ch >= CH_ZERO) && (ch <= CH_NINE)) ||
             ((ch >= CH_UP_A) && (ch <= CH_UP_Z)) ||
             ((ch >= CH_LO_A) && (ch <= CH_LO_Z));
   endfunction

endpackage

FILE: rtl/itpc_cell.sv
// itpc_cell: one entry of the shifting operator stack
// depends on itpc_pkg
module itpc_cell (
   input  logic                    clock,
   input  itpc_pkg::stack_ctl_type ctl,
   input  itpc_pkg::sym_type       from_above,
   input  itpc_pkg::sym_type       from_below,
   output itpc_pkg::sym_type       value
);

   itpc_pkg::sym_type value_ff;
   itpc_pkg::sym_type value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.push) begin
         value_in = from_above;
      end else if (ctl.pop) begin
         value_in = from_below;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

FILE: rtl/infix_to_postfix_converter_unit.sv
// infix_to_postfix_converter_unit: top level of the shunting-yard converter
// depends on itpc_pkg and itpc_cell
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_stall | req_mode, req_symbol
//   rsp_    | out       | rsp_valid/rsp_stall | rsp_out_symbol, rsp_last, rsp_overflow
//
// a beat pops and emits the stack entries it displaces one at a time, then completes
// the stack is a row of cells that shift one place a cycle while pushing or popping, unless a stalled result holds them
// a closing parenthesis drops its matching '(' in its final step, after those pops
// an end beat emits each held entry, then a terminator
// reset is synchronous and empties the stack; cell contents are left as they are
// a stalled result holds the single output register and freezes all progress
module infix_to_postfix_converter_unit #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_mode,
   input  logic [7:0]              req_symbol,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_out_symbol,
   output logic                    rsp_last,
   output logic                    rsp_overflow
);

   localparam int CntWidth = $clog2(STACK_DEPTH + 1);

   // control state
   itpc_pkg::state_type state_ff, state_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // beat held while its pops are in progress
   logic              hold_mode_ff, hold_mode_in;
   itpc_pkg::sym_type hold_sym_ff, hold_sym_in;

   // result register
   itpc_pkg::sym_type rsp_sym_ff, rsp_sym_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   // stack cells, cell 0 is the top
   itpc_pkg::sym_type     cell_q [STACK_DEPTH];
   itpc_pkg::stack_ctl_type stack_ctl;

   // step decision
   logic              slot_free;
   logic              accept;
   logic              step_en;
   logic              cur_mode;
   itpc_pkg::sym_type cur_sym;
   itpc_pkg::sym_type top_sym;
   itpc_pkg::sym_type nxt_sym;
   itpc_pkg::prec_type pc, pt, pn;
   logic              is_caret;
   logic              stack_empty, stack_full, cnt_one;
   logic              go_top, go_nxt;
   logic              emit, emit_last, emit_ovf, do_push, do_pop, done;
   itpc_pkg::sym_type emit_sym;

   // result slot is free when empty or being taken this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == itpc_pkg::ST_IDLE) && slot_free);
   assign accept    = req_valid && !req_stall;
   assign step_en   = accept || ((state_ff == itpc_pkg::ST_BUSY) && slot_free);

   // the beat being worked on: fresh from the port or the held copy
   always_comb begin
      if (state_ff == itpc_pkg::ST_IDLE) begin
         cur_mode = req_mode;
         cur_sym  = req_symbol;
      end else begin
         cur_mode = hold_mode_ff;
         cur_sym  = hold_sym_ff;
      end
   end

   assign top_sym     = cell_q[0];
   assign nxt_sym     = cell_q[1];
   assign pc          = itpc_pkg::prec_of(cur_sym);
   assign pt          = itpc_pkg::prec_of(top_sym);
   assign pn          = itpc_pkg::prec_of(nxt_sym);
   assign is_caret    = (cur_sym == itpc_pkg::CH_CARET);
   assign stack_empty = (cnt_ff == '0);
   assign stack_full  = (cnt_ff == CntWidth'(STACK_DEPTH));
   assign cnt_one     = (cnt_ff == CntWidth'(1));

   // does the top pop now, and would the entry below it pop in the following step
   // '^' only pops strictly higher precedence (right associative)
   assign go_top = !stack_empty && ((pt > pc) || ((pt == pc) && !is_caret));
   assign go_nxt = !cnt_one && ((pn > pc) || ((pn == pc) && !is_caret));

   // one step of the shunting-yard algorithm
   always_comb begin
      emit      = 1'b0;
      emit_sym  = itpc_pkg::CH_NUL;
      emit_last = 1'b0;
      emit_ovf  = 1'b0;
      do_push   = 1'b0;
      do_pop    = 1'b0;
      done      = 1'b1;
      if (cur_mode == itpc_pkg::MODE_END) begin
         // flush, then terminator
         emit = 1'b1;
         if (!stack_empty) begin
            emit_sym = top_sym;
            do_pop   = 1'b1;
            done     = 1'b0;
         end else begin
            emit_last = 1'b1;
         end
      end else if (itpc_pkg::is_blank(cur_sym)) begin
         done = 1'b1;
      end else if (itpc_pkg::is_alnum(cur_sym)) begin
         emit      = 1'b1;
         emit_sym  = cur_sym;
         emit_last = 1'b1;
      end else if (cur_sym == itpc_pkg::CH_LPAREN) begin
         if (stack_full) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            emit_ovf  = 1'b1;
         end else begin
            do_push = 1'b1;
         end
      end else if (cur_sym == itpc_pkg::CH_RPAREN) begin
         if (stack_empty) begin
            done = 1'b1;
         end else if (top_sym == itpc_pkg::CH_LPAREN) begin
            // matching parenthesis is dropped silently
            do_pop = 1'b1;
         end else begin
            emit      = 1'b1;
            emit_sym  = top_sym;
            emit_last = cnt_one || (nxt_sym == itpc_pkg::CH_LPAREN);
            do_pop    = 1'b1;
            done      = 1'b0;
         end
      end else begin
         if (go_top) begin
            // the push that follows yields nothing, so the final pop is last
            emit      = 1'b1;
            emit_sym  = top_sym;
            emit_last = !go_nxt;
            do_pop    = 1'b1;
            done      = 1'b0;
         end else if (stack_full) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            emit_ovf  = 1'b1;
         end else begin
            do_push = 1'b1;
         end
      end
   end

   assign stack_ctl.push = step_en && do_push;
   assign stack_ctl.pop  = step_en && do_pop;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itpc_pkg::ST_IDLE: begin
            if (accept && !done) begin
               state_in = itpc_pkg::ST_BUSY;
            end
         end
         itpc_pkg::ST_BUSY: begin
            if (step_en && done) begin
               state_in = itpc_pkg::ST_IDLE;
            end
         end
         default: state_in = itpc_pkg::ST_IDLE;
      endcase
   end

   // datapath and result register next values
   always_comb begin
      cnt_in       = cnt_ff;
      hold_mode_in = hold_mode_ff;
      hold_sym_in  = hold_sym_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sym_in   = rsp_sym_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (accept) begin
         hold_mode_in = req_mode;
         hold_sym_in  = req_symbol;
      end
      if (stack_ctl.push) begin
         cnt_in = cnt_ff + CntWidth'(1);
      end else if (stack_ctl.pop) begin
         cnt_in = cnt_ff - CntWidth'(1);
      end
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (step_en && emit) begin
         rsp_valid_in = 1'b1;
         rsp_sym_in   = emit_sym;
         rsp_last_in  = emit_last;
         rsp_ovf_in   = emit_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itpc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_mode_ff <= hold_mode_in;
      hold_sym_ff  <= hold_sym_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // row of cells: push shifts down from the new symbol, pop shifts up
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      itpc_pkg::sym_type above, below;
      if (i == 0) begin : g_top
         assign above = cur_sym;
      end else begin : g_mid_above
         assign above = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below = itpc_pkg::CH_NUL;
      end else begin : g_mid_below
         assign below = cell_q[i+1];
      end
      itpc_cell u_cell (
         .clock      (clock),
         .ctl        (stack_ctl),
         .from_above (above),
         .from_below (below),
         .value      (cell_q[i])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_symbol = rsp_sym_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_overflow   = rsp_ovf_ff;

endmodule
